// File: rtl/first_fit_heap_allocator_macros.svh
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_macros
// Assertion macros for the first-fit heap allocator checker.
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_HEAP_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_MACROS_SVH

// property checked at every rising clock edge outside reset
`define FFHA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition that must never be seen outside reset
`define FFHA_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// File: rtl/ffha_pkg.sv
// ----------------------------------------------------------------------------
// ffha_pkg
// Types and constants shared by the first-fit heap allocator files.
// ----------------------------------------------------------------------------
package ffha_pkg;

    localparam int ARENA_BYTES  = 65536;
    localparam int HEADER_BYTES = 16;
    localparam int ZONE_SLOTS   = ARENA_BYTES / 4;
    localparam int SLOT_W       = $clog2(ZONE_SLOTS);
    localparam int SIZE_W       = 16;
    localparam int ARENA_W      = 17;
    localparam int REQ_W        = 16;
    localparam int OFF_W        = 16;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_NOFIT = 1'b1;

    // one zone header, one entry per arena word
    typedef struct packed {
        logic [SLOT_W-1:0] next;
        logic              has_next;
        logic [SLOT_W-1:0] prev;
        logic              has_prev;
        logic [SIZE_W-1:0] size;
        logic              used;
        logic              live;
    } hdr_t;

endpackage

// File: rtl/ffha_cmd_if.sv
// ----------------------------------------------------------------------------
// ffha_cmd_if
// Command channel: allocate or free request with valid/ready.
// ----------------------------------------------------------------------------
interface ffha_cmd_if
    import ffha_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             command;
    logic [REQ_W-1:0] request_size;
    logic [OFF_W-1:0] block_offset;

    modport source (output valid, command, request_size, block_offset, input ready);
    modport sink   (input valid, command, request_size, block_offset, output ready);
endinterface

// File: rtl/ffha_rsp_if.sv
// ----------------------------------------------------------------------------
// ffha_rsp_if
// Response channel: status and payload offset with valid/ready.
// ----------------------------------------------------------------------------
interface ffha_rsp_if
    import ffha_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             status;
    logic [OFF_W-1:0] payload_offset;

    modport source (output valid, status, payload_offset, input ready);
    modport sink   (input valid, status, payload_offset, output ready);
endinterface

// File: rtl/first_fit_heap_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// First-fit allocator with coalescing; zone headers live in one RAM.
// ----------------------------------------------------------------------------
// channel   | dir | payload                                | transfer
// cmd       | in  | command, request_size, block_offset    | valid & ready
// rsp       | out | status, payload_offset                 | valid & ready
// cfg       | in  | cfg_wdata (arena_size)                 | cfg_we
//
// allocate: reads one zone header per step along the chain, then writes up to
// 3 headers; free: merges the zone with a free next and a free previous zone.
// the header RAM is simple dual-port (one read, one write per cycle, registered
// read). reset and every cfg write start a sweep that clears all 16384 headers;
// cmd.ready stays low during it. one command is in flight at a time; a
// result waits in the output register while the next command is taken.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator
    import ffha_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    ffha_cmd_if.sink           cmd,
    ffha_rsp_if.source         rsp,
    input  logic               cfg_we,
    input  logic [ARENA_W-1:0] cfg_wdata
);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_ACHK, S_ANXT, S_AWNZ, S_AWZ,
        S_FCHK, S_FNCHK, S_FNFIX, S_FHINT, S_FPCHK, S_FPFIX, S_FPWR, S_FZWR,
        S_DONE
    } state_t;

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(ZONE_SLOTS - 1);

    hdr_t mem [ZONE_SLOTS];
    hdr_t mem_q;
    logic              mem_we;
    logic [SLOT_W-1:0] mem_waddr;
    logic [SLOT_W-1:0] mem_raddr;
    hdr_t              mem_wdata;

    state_t            state_reg, state_next;
    logic [ARENA_W-1:0] arena_reg, arena_next;
    logic [SLOT_W-1:0] clr_reg, clr_next;
    logic [SLOT_W-1:0] hint_reg, hint_next;
    logic [SLOT_W-1:0] z_reg, z_next;
    logic [SLOT_W-1:0] w_reg, w_next;
    hdr_t              zh_reg, zh_next;
    hdr_t              wh_reg, wh_next;
    logic              first_reg, first_next;
    logic [SLOT_W:0]   steps_reg, steps_next;
    logic [ARENA_W-1:0] sz_reg, sz_next;
    logic              res_status_reg, res_status_next;
    logic [OFF_W-1:0]  res_payload_reg, res_payload_next;
    logic              out_valid_reg, out_valid_next;
    logic              status_reg, status_next;
    logic [OFF_W-1:0]  payload_reg, payload_next;

    logic [ARENA_W-1:0] eff_arena;
    logic [ARENA_W-1:0] arena_words;
    hdr_t               init_hdr;
    logic               fits;
    logic [SLOT_W-1:0]  nz;
    logic [ARENA_W:0]   sz_hdr;
    logic [SLOT_W-1:0]  free_slot;
    logic               free_ok;
    logic [ARENA_W-1:0] sz_req;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        mem_q <= mem[mem_raddr];
    end

    always_comb
    begin
        arena_words = {arena_reg[ARENA_W-1:2], 2'b00};
        if (arena_words > ARENA_W'(ARENA_BYTES))
        begin
            eff_arena = ARENA_W'(ARENA_BYTES);
        end
        else if (arena_words < ARENA_W'(HEADER_BYTES))
        begin
            eff_arena = ARENA_W'(HEADER_BYTES);
        end
        else
        begin
            eff_arena = arena_words;
        end
    end

    always_comb
    begin
        init_hdr      = '0;
        init_hdr.live = 1'b1;
        init_hdr.size = SIZE_W'(eff_arena - ARENA_W'(HEADER_BYTES));
    end

    assign sz_req    = ({1'b0, cmd.request_size} + ARENA_W'(3)) & ~ARENA_W'(3);
    assign sz_hdr    = {1'b0, sz_reg} + (ARENA_W+1)'(HEADER_BYTES);
    assign fits      = sz_hdr <= (ARENA_W+1)'(mem_q.size);
    assign nz        = z_reg + SLOT_W'(sz_hdr >> 2);
    assign free_slot = SLOT_W'(cmd.block_offset[OFF_W-1:2] - SLOT_W'(HEADER_BYTES / 4));
    assign free_ok   = (cmd.block_offset[1:0] == 2'b00)
                    && (cmd.block_offset >= OFF_W'(HEADER_BYTES))
                    && (({1'b0, cmd.block_offset} - ARENA_W'(HEADER_BYTES)) < eff_arena);

    assign cmd.ready          = (state_reg == S_IDLE);
    assign rsp.valid          = out_valid_reg;
    assign rsp.status         = status_reg;
    assign rsp.payload_offset = payload_reg;

    always_comb
    begin
        state_next       = state_reg;
        arena_next       = arena_reg;
        clr_next         = clr_reg;
        hint_next        = hint_reg;
        z_next           = z_reg;
        w_next           = w_reg;
        zh_next          = zh_reg;
        wh_next          = wh_reg;
        first_next       = first_reg;
        steps_next       = steps_reg;
        sz_next          = sz_reg;
        res_status_next  = res_status_reg;
        res_payload_next = res_payload_reg;
        out_valid_next   = out_valid_reg && !rsp.ready;
        status_next      = status_reg;
        payload_next     = payload_reg;
        mem_we           = 1'b0;
        mem_waddr        = z_reg;
        mem_wdata        = zh_reg;
        mem_raddr        = z_reg;

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = (clr_reg == '0) ? init_hdr : '0;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == LAST_SLOT)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (cmd.valid)
                begin
                    res_status_next  = STATUS_OK;
                    res_payload_next = '0;
                    if (cmd.command == CMD_ALLOC)
                    begin
                        mem_raddr  = hint_reg;
                        z_next     = hint_reg;
                        first_next = 1'b1;
                        steps_next = '0;
                        sz_next    = sz_req;
                        state_next = S_ACHK;
                    end
                    else if (free_ok)
                    begin
                        mem_raddr  = free_slot;
                        z_next     = free_slot;
                        state_next = S_FCHK;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_ACHK:
            begin
                zh_next = mem_q;
                if (!mem_q.used && fits)
                begin
                    w_next = nz;
                    if (mem_q.has_next)
                    begin
                        mem_raddr  = mem_q.next;
                        state_next = S_ANXT;
                    end
                    else
                    begin
                        state_next = S_AWNZ;
                    end
                end
                else
                begin
                    if (!mem_q.used)
                    begin
                        first_next = 1'b0;
                    end
                    if (!mem_q.has_next || steps_reg == (SLOT_W+1)'(ZONE_SLOTS - 1))
                    begin
                        res_status_next = STATUS_NOFIT;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        mem_raddr  = mem_q.next;
                        z_next     = mem_q.next;
                        steps_next = steps_reg + 1'b1;
                    end
                end
            end
            S_ANXT:
            begin
                mem_we             = 1'b1;
                mem_waddr          = zh_reg.next;
                mem_wdata          = mem_q;
                mem_wdata.prev     = w_reg;
                mem_wdata.has_prev = 1'b1;
                state_next         = S_AWNZ;
            end
            S_AWNZ:
            begin
                mem_we             = 1'b1;
                mem_waddr          = w_reg;
                mem_wdata.next     = zh_reg.next;
                mem_wdata.has_next = zh_reg.has_next;
                mem_wdata.prev     = z_reg;
                mem_wdata.has_prev = 1'b1;
                mem_wdata.size     = zh_reg.size - sz_reg[SIZE_W-1:0]
                                   - SIZE_W'(HEADER_BYTES);
                mem_wdata.used     = 1'b0;
                mem_wdata.live     = 1'b1;
                state_next         = S_AWZ;
            end
            S_AWZ:
            begin
                mem_we             = 1'b1;
                mem_waddr          = z_reg;
                mem_wdata          = zh_reg;
                mem_wdata.next     = w_reg;
                mem_wdata.has_next = 1'b1;
                mem_wdata.used     = 1'b1;
                mem_wdata.size     = sz_reg[SIZE_W-1:0];
                if (first_reg)
                begin
                    hint_next = w_reg;
                end
                res_payload_next = {z_reg, 2'b00} + OFF_W'(HEADER_BYTES);
                state_next       = S_DONE;
            end
            S_FCHK:
            begin
                if (!mem_q.live || !mem_q.used)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    zh_next      = mem_q;
                    zh_next.used = 1'b0;
                    if (mem_q.has_next)
                    begin
                        mem_raddr  = mem_q.next;
                        w_next     = mem_q.next;
                        state_next = S_FNCHK;
                    end
                    else
                    begin
                        state_next = S_FHINT;
                    end
                end
            end
            S_FNCHK:
            begin
                state_next = S_FHINT;
                if (!mem_q.used)
                begin
                    zh_next.next     = mem_q.next;
                    zh_next.has_next = mem_q.has_next;
                    zh_next.size     = zh_reg.size + mem_q.size + SIZE_W'(HEADER_BYTES);
                    mem_we           = 1'b1;
                    mem_waddr        = w_reg;
                    mem_wdata        = mem_q;
                    mem_wdata.live   = 1'b0;
                    if (mem_q.has_next)
                    begin
                        mem_raddr  = mem_q.next;
                        state_next = S_FNFIX;
                    end
                end
            end
            S_FNFIX:
            begin
                mem_we             = 1'b1;
                mem_waddr          = zh_reg.next;
                mem_wdata          = mem_q;
                mem_wdata.prev     = z_reg;
                mem_wdata.has_prev = 1'b1;
                state_next         = S_FHINT;
            end
            S_FHINT:
            begin
                if (z_reg < hint_reg)
                begin
                    hint_next = z_reg;
                end
                if (zh_reg.has_prev)
                begin
                    mem_raddr  = zh_reg.prev;
                    w_next     = zh_reg.prev;
                    state_next = S_FPCHK;
                end
                else
                begin
                    state_next = S_FZWR;
                end
            end
            S_FPCHK:
            begin
                state_next = S_FZWR;
                if (!mem_q.used)
                begin
                    wh_next          = mem_q;
                    wh_next.next     = zh_reg.next;
                    wh_next.has_next = zh_reg.has_next;
                    wh_next.size     = mem_q.size + zh_reg.size + SIZE_W'(HEADER_BYTES);
                    zh_next.live     = 1'b0;
                    if (w_reg < hint_reg)
                    begin
                        hint_next = w_reg;
                    end
                    if (zh_reg.has_next)
                    begin
                        mem_raddr  = zh_reg.next;
                        state_next = S_FPFIX;
                    end
                    else
                    begin
                        state_next = S_FPWR;
                    end
                end
            end
            S_FPFIX:
            begin
                mem_we             = 1'b1;
                mem_waddr          = zh_reg.next;
                mem_wdata          = mem_q;
                mem_wdata.prev     = w_reg;
                mem_wdata.has_prev = 1'b1;
                state_next         = S_FPWR;
            end
            S_FPWR:
            begin
                mem_we     = 1'b1;
                mem_waddr  = w_reg;
                mem_wdata  = wh_reg;
                state_next = S_FZWR;
            end
            S_FZWR:
            begin
                mem_we     = 1'b1;
                mem_waddr  = z_reg;
                mem_wdata  = zh_reg;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    status_next    = res_status_reg;
                    payload_next   = res_payload_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase

        // a register write restarts the heap from one free zone
        if (cfg_we)
        begin
            arena_next = cfg_wdata;
            clr_next   = '0;
            hint_next  = '0;
            state_next = S_CLEAR;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            arena_reg     <= ARENA_W'(ARENA_BYTES);
            clr_reg       <= '0;
            hint_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            arena_reg     <= arena_next;
            clr_reg       <= clr_next;
            hint_reg      <= hint_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        z_reg           <= z_next;
        w_reg           <= w_next;
        zh_reg          <= zh_next;
        wh_reg          <= wh_next;
        first_reg       <= first_next;
        steps_reg       <= steps_next;
        sz_reg          <= sz_next;
        res_status_reg  <= res_status_next;
        res_payload_reg <= res_payload_next;
        status_reg      <= status_next;
        payload_reg     <= payload_next;
    end

endmodule

// File: rtl/ffha_checker.sv
// ----------------------------------------------------------------------------
// ffha_checker
// Port-level checks for the first-fit heap allocator, bound to the top level.
// ----------------------------------------------------------------------------
`include "first_fit_heap_allocator_macros.svh"

module ffha_checker
    import ffha_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             cmd_ready,
    input logic             rsp_valid,
    input logic             rsp_ready,
    input logic             rsp_status,
    input logic [OFF_W-1:0] rsp_payload_offset,
    input logic             cfg_we
);

    logic rsp_stall;
    logic rsp_nofit;
    logic bad_offset;

    assign rsp_stall  = rsp_valid && !rsp_ready;
    assign rsp_nofit  = rsp_valid && (rsp_status == STATUS_NOFIT);
    assign bad_offset = (rsp_payload_offset[1:0] != 2'b00)
                     || (rsp_payload_offset < OFF_W'(HEADER_BYTES));

    `FFHA_ASSERT(a_rsp_hold, rsp_stall |=> rsp_valid, "rsp valid dropped")
    `FFHA_ASSERT(a_rsp_stable, rsp_stall |=> $stable(rsp_payload_offset), "rsp payload moved")
    `FFHA_NEVER(a_nofit_zero, rsp_nofit && rsp_payload_offset != '0, "no-fit with payload")
    `FFHA_NEVER(a_payload_align, rsp_valid && rsp_payload_offset != '0 && bad_offset, "bad offset")
    `FFHA_ASSERT(a_cfg_sweep, cfg_we |=> !cmd_ready, "command taken during heap sweep")

endmodule

bind first_fit_heap_allocator ffha_checker u_ffha_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd_ready          (cmd.ready),
    .rsp_valid          (rsp.valid),
    .rsp_ready          (rsp.ready),
    .rsp_status         (rsp.status),
    .rsp_payload_offset (rsp.payload_offset),
    .cfg_we             (cfg_we)
);

// File: sim/ffha_tb_if.sv
// ----------------------------------------------------------------------------
// ffha_tb_if
// Configuration write signals driven by the allocator testbench.
// ----------------------------------------------------------------------------
interface ffha_tb_if
    import ffha_pkg::*;
();
    logic               cfg_we;
    logic [ARENA_W-1:0] cfg_wdata;

    modport source (output cfg_we, cfg_wdata);
    modport sink   (input cfg_we, cfg_wdata);
endinterface

// File: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives allocate and free commands into the first-fit heap allocator,
// mirrors the zone chain in a local heap model and checks every response.
// ----------------------------------------------------------------------------
module testbench
    import ffha_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 200000;

    logic clk;
    logic rst_n;
    int errors;

    ffha_cmd_if cmd ();
    ffha_rsp_if rsp ();
    ffha_tb_if  cfg_bus ();

    first_fit_heap_allocator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .rsp       (rsp),
        .cfg_we    (cfg_bus.cfg_we),
        .cfg_wdata (cfg_bus.cfg_wdata)
    );

    typedef struct {
        logic              status;
        logic [OFF_W-1:0]  payload_offset;
    } alloc_result_t;

    task automatic report_mismatch(input string msg);
        $display("mismatch: %s", msg);
        errors++;
    endtask

    // local copy of the heap plus the queue of expected responses
    class heap_scoreboard;
        int unsigned next_z[ZONE_SLOTS];
        int unsigned prev_z[ZONE_SLOTS];
        bit has_next[ZONE_SLOTS];
        bit has_prev[ZONE_SLOTS];
        int unsigned zsize[ZONE_SLOTS];
        bit used[ZONE_SLOTS];
        bit live[ZONE_SLOTS];
        int unsigned hint;
        int unsigned arena;
        alloc_result_t pending[$];
        int unsigned owned[$];

        function int unsigned effective_arena();
            int unsigned e;
            e = arena & ~32'd3;
            if (e > ARENA_BYTES) e = ARENA_BYTES;
            if (e < HEADER_BYTES) e = HEADER_BYTES;
            return e;
        endfunction

        function void set_arena(int unsigned value);
            arena = value & 32'h1FFFF;
            for (int i = 0; i < ZONE_SLOTS; i++)
            begin
                next_z[i] = 0; prev_z[i] = 0; has_next[i] = 0; has_prev[i] = 0;
                zsize[i] = 0; used[i] = 0; live[i] = 0;
            end
            live[0] = 1;
            zsize[0] = effective_arena() - HEADER_BYTES;
            hint = 0;
            owned.delete();
        endfunction

        function alloc_result_t allocate(int unsigned req);
            alloc_result_t r;
            int unsigned sz, z, nz, n;
            bit first;
            sz = (req + 3) & ~32'd3;
            z = hint % ZONE_SLOTS;
            first = 1;
            r.status = STATUS_NOFIT;
            r.payload_offset = '0;
            for (int steps = 0; steps < ZONE_SLOTS; steps++)
            begin
                if (!used[z])
                begin
                    if (sz + HEADER_BYTES <= zsize[z])
                    begin
                        nz = (z + (HEADER_BYTES + sz) / 4) % ZONE_SLOTS;
                        if (has_next[z])
                        begin
                            n = next_z[z] % ZONE_SLOTS;
                            prev_z[n] = nz;
                            has_prev[n] = 1;
                        end
                        next_z[nz] = next_z[z];
                        has_next[nz] = has_next[z];
                        prev_z[nz] = z;
                        has_prev[nz] = 1;
                        used[nz] = 0;
                        live[nz] = 1;
                        zsize[nz] = zsize[z] - sz - HEADER_BYTES;
                        next_z[z] = nz;
                        has_next[z] = 1;
                        used[z] = 1;
                        zsize[z] = sz;
                        if (first) hint = nz;
                        r.status = STATUS_OK;
                        r.payload_offset = OFF_W'(z * 4 + HEADER_BYTES);
                        owned.push_back(z * 4 + HEADER_BYTES);
                        return r;
                    end
                    first = 0;
                end
                if (!has_next[z]) break;
                z = next_z[z] % ZONE_SLOTS;
            end
            return r;
        endfunction

        function void release_block(int unsigned off);
            int unsigned z, w, n;
            if ((off & 3) != 0 || off < HEADER_BYTES) return;
            if (off - HEADER_BYTES >= effective_arena()) return;
            z = ((off - HEADER_BYTES) / 4) % ZONE_SLOTS;
            if (!live[z] || !used[z]) return;
            used[z] = 0;
            if (has_next[z])
            begin
                w = next_z[z] % ZONE_SLOTS;
                if (!used[w])
                begin
                    next_z[z] = next_z[w];
                    has_next[z] = has_next[w];
                    if (has_next[w])
                    begin
                        n = next_z[w] % ZONE_SLOTS;
                        prev_z[n] = z;
                        has_prev[n] = 1;
                    end
                    zsize[z] = zsize[z] + zsize[w] + HEADER_BYTES;
                    live[w] = 0;
                end
            end
            if (z < hint) hint = z;
            if (has_prev[z])
            begin
                w = prev_z[z] % ZONE_SLOTS;
                if (!used[w])
                begin
                    next_z[w] = next_z[z];
                    has_next[w] = has_next[z];
                    if (has_next[z])
                    begin
                        n = next_z[z] % ZONE_SLOTS;
                        prev_z[n] = w;
                        has_prev[n] = 1;
                    end
                    zsize[w] = zsize[w] + zsize[z] + HEADER_BYTES;
                    live[z] = 0;
                    if (w < hint) hint = w;
                end
            end
        endfunction

        function void note_command(logic c, logic [REQ_W-1:0] req, logic [OFF_W-1:0] off);
            alloc_result_t r;
            if (c == CMD_ALLOC)
                r = allocate(req);
            else
            begin
                release_block(off);
                r.status = STATUS_OK;
                r.payload_offset = '0;
            end
            pending.push_back(r);
        endfunction

        function string check_response(logic st, logic [OFF_W-1:0] off);
            alloc_result_t e;
            if (pending.size() == 0)
                return $sformatf("unexpected response status %0d offset %0d", st, off);
            e = pending.pop_front();
            if (st !== e.status || off !== e.payload_offset)
                return $sformatf("got status %0d offset %0d, want %0d %0d",
                                 st, off, e.status, e.payload_offset);
            return "";
        endfunction
    endclass

    heap_scoreboard heap;
    int idle_cycles;

    always #2 clk = ~clk;

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // response side: random stalls, check on each transfer
    initial
    begin
        string msg;
        int stall_left;
        rsp.ready = 1'b0;
        stall_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                rsp.ready = 1'b0;
                stall_left--;
            end
            else
            begin
                rsp.ready = 1'b1;
                stall_left = gap_len();
            end
            @(posedge clk);
            if (rsp.valid && rsp.ready)
            begin
                msg = heap.check_response(rsp.status, rsp.payload_offset);
                if (msg != "") report_mismatch(msg);
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if (!rst_n || (cmd.valid && cmd.ready) || (rsp.valid && rsp.ready) || cfg_bus.cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic send_command(input logic c, input int unsigned req, input int unsigned off);
        repeat (gap_len()) @(negedge clk);
        cmd.valid = 1'b1;
        cmd.command = c;
        cmd.request_size = REQ_W'(req);
        cmd.block_offset = OFF_W'(off);
        do @(posedge clk); while (!cmd.ready);
        heap.note_command(c, cmd.request_size, cmd.block_offset);
        @(negedge clk);
        cmd.valid = 1'b0;
        cmd.command = 1'($urandom_range(0, 1));
        cmd.request_size = REQ_W'($urandom);
        cmd.block_offset = OFF_W'($urandom);
    endtask

    task automatic wait_drained();
        while (heap.pending.size() != 0) @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic write_arena(input int unsigned value);
        wait_drained();
        cfg_bus.cfg_wdata = ARENA_W'(value);
        cfg_bus.cfg_we = 1'b1;
        @(posedge clk);
        heap.set_arena(value);
        @(negedge clk);
        cfg_bus.cfg_we = 1'b0;
    endtask

    task automatic free_owned_random();
        int k;
        if (heap.owned.size() == 0)
        begin
            send_command(CMD_FREE, $urandom, $urandom);
            return;
        end
        k = $urandom_range(0, heap.owned.size() - 1);
        send_command(CMD_FREE, $urandom, heap.owned[k]);
        heap.owned.delete(k);
    endtask

    task automatic random_phase(input int count, input int unsigned max_req);
        int p;
        for (int i = 0; i < count; i++)
        begin
            p = $urandom_range(0, 99);
            if (p < 50)
                send_command(CMD_ALLOC, $urandom_range(0, max_req), $urandom);
            else if (p < 88)
                free_owned_random();
            else if (p < 93)
                send_command(CMD_ALLOC, $urandom, $urandom);
            else
                send_command(CMD_FREE, $urandom, $urandom);
        end
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        errors = 0;
        cfg_bus.cfg_we = 1'b0;
        cfg_bus.cfg_wdata = '0;
        cmd.valid = 1'b0;
        cmd.command = CMD_ALLOC;
        cmd.request_size = '0;
        cmd.block_offset = '0;
        heap = new();
        heap.set_arena(65536);
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        // directed: extremes, zero request, bad frees, repeated free of a non-block, merges
        send_command(CMD_ALLOC, 0, 0);
        send_command(CMD_ALLOC, 1, 16'hFFFF);
        send_command(CMD_ALLOC, 65535, 0);
        send_command(CMD_ALLOC, 100, 0);
        send_command(CMD_FREE, 0, 18);
        send_command(CMD_FREE, 0, 4);
        send_command(CMD_FREE, 0, 20);
        send_command(CMD_FREE, 16'hFFFF, 65535);
        send_command(CMD_FREE, 0, 36);
        send_command(CMD_FREE, 0, 36);
        send_command(CMD_FREE, 0, 16);
        send_command(CMD_FREE, 0, 56);
        send_command(CMD_ALLOC, 65000, 0);
        send_command(CMD_ALLOC, 65504, 0);
        write_arena(32);
        send_command(CMD_ALLOC, 0, 0);
        send_command(CMD_ALLOC, 1, 0);
        send_command(CMD_FREE, 0, 16);
        write_arena(16);
        send_command(CMD_ALLOC, 0, 0);
        write_arena(3);
        send_command(CMD_ALLOC, 0, 0);
        write_arena(20'h1FFFF);
        send_command(CMD_ALLOC, 65504, 0);
        send_command(CMD_FREE, 0, 16);

        // random phases over several arena sizes
        write_arena(256);
        random_phase(200, 40);
        write_arena(($urandom_range(8, 1024)) * 4 + $urandom_range(0, 3));
        random_phase(200, 300);
        write_arena(65536);
        random_phase(150, 4000);
        write_arena(2048);
        random_phase(230, 120);

        wait_drained();
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
